// ===== hw/rtl/hjtb_pkg.sv =====
// Package for the hash-join table build unit.
// Holds the channel payload types, status codes, register indexes and hash constant.
// No dependencies.
package hjtb_pkg;

   localparam logic [31:0] MIX_M = 32'hc6a4a793;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_OCCUPIED = 2'd1;
   localparam logic [1:0] STATUS_FULL     = 2'd2;

   localparam logic [2:0] REG_SLOTS_IN_USE  = 3'd0;
   localparam logic [2:0] REG_KEY_PARTS     = 3'd1;
   localparam logic [2:0] REG_WIDE_KEYS     = 3'd2;
   localparam logic [2:0] REG_WITH_VALUE    = 3'd3;
   localparam logic [2:0] REG_SEMI_JOIN     = 3'd4;
   localparam logic [2:0] REG_EMPTY_KEY     = 3'd5;
   localparam logic [2:0] REG_INVALID_VALUE = 3'd6;

   typedef struct packed {
      logic               mode;
      logic signed [63:0] key_part0;
      logic signed [63:0] key_part1;
      logic signed [63:0] key_part2;
      logic signed [63:0] key_part3;
      logic signed [31:0] row_id;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [9:0] slot_index;
   } rsp_type;

endpackage

// ===== hw/rtl/hjtb_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Used for the key rows and the value slots. No dependencies.
module hjtb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/hash_join_table_build_unit.sv =====
// Top level of the hash-join table build unit: hash sequencer, divider and probe loop.
// Depends on hjtb_pkg and hjtb_ram.
//
// Usage: an item is transferred on the req_ channel when req_valid is high and
// req_stall is low; one result per item is transferred on the rsp_ channel in the
// same way. Registers are written through csr_we, csr_index and csr_wdata; the user
// must write them only while the unit is idle; the unit itself does not enforce it.
// An insert item hashes its key with one shared 32-bit multiplier: a length term,
// then each 32-bit key word in turn, then the finish. The home slot is then found
// by a restoring divider as the remainder of the hash by the slots in use. Each
// probe passes through S_RD, for the registered read of the key row memory, and
// S_CMP; S_RESP then hands over the result.
// A clear item sweeps the key and value memories, one slot per cycle, over all
// TABLE_SLOTS slots before its result.
// After reset the same sweep runs with the reset register values, and req_stall
// stays high until it is over.
// The unit takes one item at a time. A finished result is held in the output
// register while rsp_stall is high; a new item may be taken meanwhile, but its
// result waits until the held one has been transferred.
module hash_join_table_build_unit
   import hjtb_pkg::*;
#(
   parameter int TABLE_SLOTS   = 1024,
   parameter int MAX_KEY_PARTS = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_wdata
);

   localparam int AW  = $clog2(TABLE_SLOTS);
   localparam int SCW = $clog2(TABLE_SLOTS + 1);
   localparam int CW  = (SCW > 11) ? SCW : 11;
   localparam int PCW = $clog2(MAX_KEY_PARTS + 1);
   localparam int PW  = (PCW > 3) ? PCW : 3;
   localparam int KIW = (MAX_KEY_PARTS > 1) ? $clog2(MAX_KEY_PARTS) : 1;
   localparam int RW  = 64 * MAX_KEY_PARTS;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_SWEEP = 4'd1;
   localparam logic [3:0] S_HMUL  = 4'd2;
   localparam logic [3:0] S_HPOST = 4'd3;
   localparam logic [3:0] S_DIV   = 4'd4;
   localparam logic [3:0] S_RD    = 4'd5;
   localparam logic [3:0] S_CMP   = 4'd6;
   localparam logic [3:0] S_RESP  = 4'd7;

   localparam logic [1:0] PH_LEN  = 2'd0;
   localparam logic [1:0] PH_WORD = 2'd1;
   localparam logic [1:0] PH_FIN1 = 2'd2;
   localparam logic [1:0] PH_FIN2 = 2'd3;

   logic [10:0] slots_ff, slots_in;
   logic [2:0]  parts_reg_ff, parts_reg_in;
   logic        wide_ff, wide_in;
   logic        with_value_ff, with_value_in;
   logic        semi_ff, semi_in;
   logic [63:0] empty_ff, empty_in;
   logic [31:0] invalid_ff, invalid_in;

   logic [3:0]  state_ff, state_in;
   logic [1:0]  phase_ff, phase_in;
   logic [PW:0] word_ff, word_in;
   logic [31:0] h_ff, h_in;
   logic [31:0] mul_ff, mul_in;
   logic [4:0]  bit_ff, bit_in;
   logic [CW:0] rem_ff, rem_in;
   logic [AW-1:0] probe_ff, probe_in;
   logic [CW-1:0] step_ff, step_in;
   logic [AW-1:0] sweep_ff, sweep_in;
   logic [63:0] sweep_key_ff, sweep_key_in;
   logic [31:0] sweep_val_ff, sweep_val_in;
   logic        clr_ff, clr_in;
   logic [63:0] key_ff [MAX_KEY_PARTS];
   logic [63:0] key_in [MAX_KEY_PARTS];
   logic [31:0] row_id_ff, row_id_in;
   logic [1:0]  res_status_ff, res_status_in;
   logic [AW-1:0] res_slot_ff, res_slot_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;

   logic [CW-1:0] n_eff;
   logic [PW-1:0] parts_eff;
   logic [PW:0]   nwords;
   logic [63:0]   mask;
   logic [63:0]   req_parts [4];
   logic [KIW-1:0] word_part;
   logic [63:0]   word_src;
   logic [31:0]   key_word;
   logic [31:0]   mul_a;
   logic [31:0]   post;
   logic [CW:0]   rem_shift;
   logic [CW-1:0] probe_next;

   logic          key_we, val_we;
   logic [AW-1:0] key_waddr;
   logic [RW-1:0] key_wdata, key_row, merged_row;
   logic [31:0]   val_wdata, val_row;
   logic          row_empty, row_equal;

   hjtb_ram #(.WIDTH(RW), .DEPTH(TABLE_SLOTS)) u_key_ram (
      .clock   (clock),
      .wr_en   (key_we),
      .wr_addr (key_waddr),
      .wr_data (key_wdata),
      .rd_addr (probe_ff),
      .rd_data (key_row)
   );

   hjtb_ram #(.WIDTH(32), .DEPTH(TABLE_SLOTS)) u_val_ram (
      .clock   (clock),
      .wr_en   (val_we),
      .wr_addr (key_waddr),
      .wr_data (val_wdata),
      .rd_addr (probe_ff),
      .rd_data (val_row)
   );

   always_comb begin
      slots_in      = slots_ff;
      parts_reg_in  = parts_reg_ff;
      wide_in       = wide_ff;
      with_value_in = with_value_ff;
      semi_in       = semi_ff;
      empty_in      = empty_ff;
      invalid_in    = invalid_ff;
      if (csr_we) begin
         case (csr_index)
            REG_SLOTS_IN_USE:  slots_in      = csr_wdata[10:0];
            REG_KEY_PARTS:     parts_reg_in  = csr_wdata[2:0];
            REG_WIDE_KEYS:     wide_in       = csr_wdata[0];
            REG_WITH_VALUE:    with_value_in = csr_wdata[0];
            REG_SEMI_JOIN:     semi_in       = csr_wdata[0];
            REG_EMPTY_KEY:     empty_in      = csr_wdata;
            REG_INVALID_VALUE: invalid_in    = csr_wdata[31:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (slots_ff == 11'd0) begin
         n_eff = CW'(1);
      end else if (CW'(slots_ff) > CW'(TABLE_SLOTS)) begin
         n_eff = CW'(TABLE_SLOTS);
      end else begin
         n_eff = CW'(slots_ff);
      end
      if (parts_reg_ff == 3'd0) begin
         parts_eff = PW'(1);
      end else if (PW'(parts_reg_ff) > PW'(MAX_KEY_PARTS)) begin
         parts_eff = PW'(MAX_KEY_PARTS);
      end else begin
         parts_eff = PW'(parts_reg_ff);
      end
      nwords = wide_ff ? {parts_eff, 1'b0} : {1'b0, parts_eff};
      mask   = wide_ff ? 64'hffff_ffff_ffff_ffff : 64'h0000_0000_ffff_ffff;

      req_parts[0] = req_data.key_part0;
      req_parts[1] = req_data.key_part1;
      req_parts[2] = req_data.key_part2;
      req_parts[3] = req_data.key_part3;

      word_part = wide_ff ? KIW'(word_ff >> 1) : KIW'(word_ff);
      word_src  = key_ff[word_part];
      key_word  = (wide_ff && word_ff[0]) ? word_src[63:32] : word_src[31:0];

      case (phase_ff)
         PH_LEN:  mul_a = 32'(nwords) << 2;
         PH_WORD: mul_a = h_ff + key_word;
         default: mul_a = h_ff;
      endcase
      mul_in = mul_a * MIX_M;

      case (phase_ff)
         PH_LEN:  post = mul_ff;
         PH_WORD: post = mul_ff ^ (mul_ff >> 16);
         PH_FIN1: post = mul_ff ^ (mul_ff >> 10);
         default: post = mul_ff ^ (mul_ff >> 17);
      endcase

      rem_shift  = {rem_ff[CW-1:0], h_ff[31]};
      probe_next = CW'(probe_ff) + CW'(1);

      row_empty = (key_row[63:0] & mask) == (empty_ff & mask);
      row_equal = 1'b1;
      for (int c = 0; c < MAX_KEY_PARTS; c++) begin
         if (PW'(c) < parts_eff) begin
            merged_row[c*64 +: 64] = key_ff[c];
            if ((key_row[c*64 +: 64] & mask) != key_ff[c]) begin
               row_equal = 1'b0;
            end
         end else begin
            merged_row[c*64 +: 64] = key_row[c*64 +: 64];
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      word_in       = word_ff;
      h_in          = h_ff;
      bit_in        = bit_ff;
      rem_in        = rem_ff;
      probe_in      = probe_ff;
      step_in       = step_ff;
      sweep_in      = sweep_ff;
      sweep_key_in  = sweep_key_ff;
      sweep_val_in  = sweep_val_ff;
      clr_in        = clr_ff;
      row_id_in     = row_id_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      for (int c = 0; c < MAX_KEY_PARTS; c++) begin
         key_in[c] = key_ff[c];
      end
      key_we    = 1'b0;
      val_we    = 1'b0;
      key_waddr = probe_ff;
      key_wdata = merged_row;
      val_wdata = row_id_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_data.mode) begin
                  sweep_in     = '0;
                  sweep_key_in = empty_ff;
                  sweep_val_in = invalid_ff;
                  clr_in       = 1'b1;
                  state_in     = S_SWEEP;
               end else begin
                  for (int c = 0; c < MAX_KEY_PARTS; c++) begin
                     if (c < 4 && PW'(c) < parts_eff) begin
                        key_in[c] = req_parts[c % 4] & mask;
                     end else begin
                        key_in[c] = '0;
                     end
                  end
                  row_id_in = req_data.row_id;
                  phase_in  = PH_LEN;
                  state_in  = S_HMUL;
               end
            end
         end
         S_SWEEP: begin
            key_we    = 1'b1;
            val_we    = 1'b1;
            key_waddr = sweep_ff;
            key_wdata = {MAX_KEY_PARTS{sweep_key_ff}};
            val_wdata = sweep_val_ff;
            sweep_in  = sweep_ff + AW'(1);
            if (sweep_ff == AW'(TABLE_SLOTS - 1)) begin
               if (clr_ff) begin
                  res_status_in = STATUS_OK;
                  res_slot_in   = '0;
                  state_in      = S_RESP;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_HMUL: begin
            state_in = S_HPOST;
         end
         S_HPOST: begin
            h_in     = post;
            state_in = S_HMUL;
            case (phase_ff)
               PH_LEN: begin
                  phase_in = PH_WORD;
                  word_in  = '0;
               end
               PH_WORD: begin
                  word_in = word_ff + 1'b1;
                  if (word_ff == nwords - 1'b1) begin
                     phase_in = PH_FIN1;
                  end
               end
               PH_FIN1: begin
                  phase_in = PH_FIN2;
               end
               default: begin
                  bit_in   = '0;
                  rem_in   = '0;
                  state_in = S_DIV;
               end
            endcase
         end
         S_DIV: begin
            h_in   = h_ff << 1;
            bit_in = bit_ff + 1'b1;
            if (rem_shift >= {1'b0, n_eff}) begin
               rem_in = rem_shift - {1'b0, n_eff};
            end else begin
               rem_in = rem_shift;
            end
            if (bit_ff == 5'd31) begin
               probe_in = AW'(rem_in);
               step_in  = '0;
               state_in = S_RD;
            end
         end
         S_RD: begin
            state_in = S_CMP;
         end
         S_CMP: begin
            if (row_empty || row_equal) begin
               key_we        = row_empty;
               res_slot_in   = probe_ff;
               res_status_in = STATUS_OK;
               if (with_value_ff) begin
                  if (val_row == invalid_ff) begin
                     val_we = 1'b1;
                  end else if (!semi_ff) begin
                     res_status_in = STATUS_OCCUPIED;
                  end
               end
               clr_in   = 1'b0;
               state_in = S_RESP;
            end else if (step_ff == n_eff - CW'(1)) begin
               res_slot_in   = '0;
               res_status_in = STATUS_FULL;
               clr_in        = 1'b0;
               state_in      = S_RESP;
            end else begin
               probe_in = (probe_next == n_eff) ? '0 : AW'(probe_next);
               step_in  = step_ff + CW'(1);
               state_in = S_RD;
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.status     = res_status_ff;
               rsp_data_in.slot_index = 10'(res_slot_ff);
               clr_in                 = 1'b0;
               state_in               = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slots_ff      <= 11'd1024;
         parts_reg_ff  <= 3'd1;
         wide_ff       <= 1'b1;
         with_value_ff <= 1'b1;
         semi_ff       <= 1'b0;
         empty_ff      <= 64'h7fff_ffff_ffff_ffff;
         invalid_ff    <= 32'hffff_ffff;
         state_ff      <= S_SWEEP;
         sweep_ff      <= '0;
         sweep_key_ff  <= 64'h7fff_ffff_ffff_ffff;
         sweep_val_ff  <= 32'hffff_ffff;
         clr_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         slots_ff      <= slots_in;
         parts_reg_ff  <= parts_reg_in;
         wide_ff       <= wide_in;
         with_value_ff <= with_value_in;
         semi_ff       <= semi_in;
         empty_ff      <= empty_in;
         invalid_ff    <= invalid_in;
         state_ff      <= state_in;
         sweep_ff      <= sweep_in;
         sweep_key_ff  <= sweep_key_in;
         sweep_val_ff  <= sweep_val_in;
         clr_ff        <= clr_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      phase_ff      <= phase_in;
      word_ff       <= word_in;
      h_ff          <= h_in;
      mul_ff        <= mul_in;
      bit_ff        <= bit_in;
      rem_ff        <= rem_in;
      probe_ff      <= probe_in;
      step_ff       <= step_in;
      row_id_ff     <= row_id_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      rsp_data_ff   <= rsp_data_in;
      for (int c = 0; c < MAX_KEY_PARTS; c++) begin
         key_ff[c] <= key_in[c];
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_sweep_stalls: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SWEEP |-> req_stall)
      else $error("input taken during table sweep");

   a_rsp_from_resp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_RESP)
      else $error("result raised outside the response state");

   a_full_slot_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.status == STATUS_FULL |-> rsp_data_ff.slot_index == 10'd0)
      else $error("full status with a non-zero slot");

   a_probe_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CMP |-> CW'(probe_ff) < n_eff)
      else $error("probe beyond the slots in use");

endmodule
